### hw/rtl/pinned_lru_slot_cache_unit_defines.svh
// Assertion macros for the pinned LRU slot cache datapath.
`ifndef PINNED_LRU_SLOT_CACHE_UNIT_DEFINES_SVH
`define PINNED_LRU_SLOT_CACHE_UNIT_DEFINES_SVH

// Same-cycle implication, checked at every rising clock edge outside reset.
`define PLSC_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("plsc assertion failed");

// Next-cycle implication, checked at every rising clock edge outside reset.
`define PLSC_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("plsc assertion failed");

`endif

### hw/rtl/plsc_pkg.sv
// Types and constants shared by the pinned LRU slot cache modules.
package plsc_pkg;

   localparam int CMD_BITS    = 2;
   localparam int SLOT_BITS   = 4;
   localparam int OWNER_BITS  = 16;
   localparam int NOW_BITS    = 32;
   localparam int STATUS_BITS = 2;

   typedef enum logic [CMD_BITS-1:0] {
      CMD_ACQUIRE = 2'd0,
      CMD_TOUCH   = 2'd1,
      CMD_RELEASE = 2'd2,
      CMD_DROP    = 2'd3
   } cmd_type;

   typedef enum logic [STATUS_BITS-1:0] {
      ST_OK     = 2'd0,
      ST_FULL   = 2'd1,
      ST_BAD    = 2'd2,
      ST_IN_USE = 2'd3
   } status_type;

   typedef enum logic [1:0] {
      S_IDLE,
      S_DECODE,
      S_SCAN,
      S_FINISH
   } state_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic load_req;
      logic rd_slot;
      logic scan_start;
      logic scan_step;
      logic commit;
   } ctrl_cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic is_acquire;
      logic slot_bad;
      logic scan_last;
      logic out_free;
   } dp_status_type;

endpackage

### hw/rtl/plsc_ram.sv
// Generic single-write, single-read RAM with registered read data.
module plsc_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem_ff[rd_addr];
      end
   end

endmodule

### hw/rtl/plsc_ctrl.sv
// Controller state machine that sequences each request through the datapath.
module plsc_ctrl
   import plsc_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          req_valid,
   output logic          req_ready,
   input  dp_status_type dp_status,
   output ctrl_cmd_type  ctrl_cmd
);

   state_type state_ff;
   state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE: begin
            if (req_valid) state_in = S_DECODE;
         end
         S_DECODE: begin
            if (dp_status.is_acquire) state_in = S_SCAN;
            else                      state_in = S_FINISH;
         end
         S_SCAN: begin
            if (dp_status.scan_last) state_in = S_FINISH;
         end
         S_FINISH: begin
            if (dp_status.out_free) state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_comb begin
      req_ready = 1'b0;
      ctrl_cmd  = '0;
      case (state_ff)
         S_IDLE: begin
            req_ready         = 1'b1;
            ctrl_cmd.load_req = req_valid;
         end
         S_DECODE: begin
            ctrl_cmd.scan_start = dp_status.is_acquire;
            ctrl_cmd.rd_slot    = !dp_status.is_acquire && !dp_status.slot_bad;
         end
         S_SCAN: begin
            ctrl_cmd.scan_step = 1'b1;
         end
         S_FINISH: begin
            ctrl_cmd.commit = dp_status.out_free;
         end
         default: begin
            req_ready = 1'b0;
         end
      endcase
   end

endmodule

### hw/rtl/plsc_datapath.sv
// Datapath: entry table, acquire scan registers and the result register.
`include "pinned_lru_slot_cache_unit_defines.svh"

module plsc_datapath
   import plsc_pkg::*;
#(
   parameter int ENTRIES   = 16,
   parameter int USE_BITS  = 8,
   parameter int TIME_BITS = 32
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic [CMD_BITS-1:0]    req_cmd,
   input  logic [SLOT_BITS-1:0]   req_slot,
   input  logic [OWNER_BITS-1:0]  req_owner_id,
   input  logic [NOW_BITS-1:0]    req_now,
   input  ctrl_cmd_type           ctrl_cmd,
   output dp_status_type          dp_status,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output logic [STATUS_BITS-1:0] rsp_status,
   output logic [SLOT_BITS-1:0]   rsp_granted_slot,
   output logic                   rsp_evicted,
   output logic [OWNER_BITS-1:0]  rsp_evicted_owner
);

   localparam int IDX_W  = $clog2(ENTRIES);
   localparam int WORD_W = OWNER_BITS + USE_BITS + TIME_BITS;

   // Latched request.
   cmd_type               cmd_ff;
   logic [SLOT_BITS-1:0]  slot_ff;
   logic [OWNER_BITS-1:0] owner_ff;
   logic [NOW_BITS-1:0]   now_ff;

   // Entry valid bits; an invalid entry counts as empty, whatever the RAM holds.
   logic [ENTRIES-1:0] valid_ff;

   // Acquire scan state.
   logic [IDX_W-1:0]      scan_cnt_ff;
   logic                  found_empty_ff;
   logic                  found_old_ff;
   logic [IDX_W-1:0]      pick_ff;
   logic [TIME_BITS-1:0]  oldest_ff;
   logic [OWNER_BITS-1:0] best_owner_ff;

   // Result register.
   logic                  rsp_valid_ff;
   status_type            rsp_status_ff;
   logic [SLOT_BITS-1:0]  rsp_slot_ff;
   logic                  rsp_evicted_ff;
   logic [OWNER_BITS-1:0] rsp_owner_ff;

   // RAM interface.
   logic                  ram_wr_en;
   logic [IDX_W-1:0]      ram_wr_addr;
   logic [WORD_W-1:0]     ram_wr_data;
   logic                  ram_rd_en;
   logic [IDX_W-1:0]      ram_rd_addr;
   logic [WORD_W-1:0]     ram_rd_data;

   logic [OWNER_BITS-1:0] q_owner;
   logic [USE_BITS-1:0]   q_uses;
   logic [TIME_BITS-1:0]  q_time;

   logic [IDX_W-1:0]      slot_idx;
   logic                  slot_bad;
   logic                  slot_valid;
   logic                  scan_last;
   logic                  scan_valid;

   // Commit decisions.
   logic                  wr_en_in;
   logic [IDX_W-1:0]      wr_addr_in;
   logic [WORD_W-1:0]     wr_data_in;
   logic                  set_valid_in;
   logic                  clr_valid_in;
   status_type            rsp_status_in;
   logic [SLOT_BITS-1:0]  rsp_slot_in;
   logic                  rsp_evicted_in;
   logic [OWNER_BITS-1:0] rsp_owner_in;

   assign q_owner = ram_rd_data[WORD_W-1 -: OWNER_BITS];
   assign q_uses  = ram_rd_data[TIME_BITS +: USE_BITS];
   assign q_time  = ram_rd_data[TIME_BITS-1:0];

   assign slot_idx   = IDX_W'(slot_ff);
   assign slot_bad   = int'(slot_ff) >= ENTRIES;
   assign slot_valid = valid_ff[slot_idx];
   assign scan_last  = scan_cnt_ff == IDX_W'(ENTRIES - 1);
   assign scan_valid = valid_ff[scan_cnt_ff];

   assign dp_status.is_acquire = cmd_ff == CMD_ACQUIRE;
   assign dp_status.slot_bad   = slot_bad;
   assign dp_status.scan_last  = scan_last;
   assign dp_status.out_free   = !rsp_valid_ff || rsp_ready;

   always_comb begin
      if (ctrl_cmd.rd_slot)         ram_rd_addr = slot_idx;
      else if (ctrl_cmd.scan_start) ram_rd_addr = '0;
      else                          ram_rd_addr = scan_cnt_ff + 1'b1;
   end

   assign ram_rd_en = ctrl_cmd.rd_slot || ctrl_cmd.scan_start
                   || (ctrl_cmd.scan_step && !scan_last);

   assign ram_wr_en   = ctrl_cmd.commit && wr_en_in;
   assign ram_wr_addr = wr_addr_in;
   assign ram_wr_data = wr_data_in;

   plsc_ram #(
      .WIDTH (WORD_W),
      .DEPTH (ENTRIES)
   ) u_table (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   always_ff @(posedge clock) begin
      if (ctrl_cmd.load_req) begin
         cmd_ff   <= cmd_type'(req_cmd);
         slot_ff  <= req_slot;
         owner_ff <= req_owner_id;
         now_ff   <= req_now;
      end
   end

   // One entry per cycle: the first empty entry wins outright, otherwise the
   // oldest unused occupied entry, with the lower index kept on equal times.
   always_ff @(posedge clock) begin
      if (ctrl_cmd.scan_start) begin
         scan_cnt_ff    <= '0;
         found_empty_ff <= 1'b0;
         found_old_ff   <= 1'b0;
      end else if (ctrl_cmd.scan_step) begin
         scan_cnt_ff <= scan_cnt_ff + 1'b1;
         if (!found_empty_ff) begin
            if (!scan_valid) begin
               found_empty_ff <= 1'b1;
               pick_ff        <= scan_cnt_ff;
            end else if (q_uses == '0 && (!found_old_ff || q_time < oldest_ff)) begin
               found_old_ff  <= 1'b1;
               oldest_ff     <= q_time;
               pick_ff       <= scan_cnt_ff;
               best_owner_ff <= q_owner;
            end
         end
      end
   end

   always_comb begin
      wr_en_in       = 1'b0;
      wr_addr_in     = slot_idx;
      wr_data_in     = {q_owner, q_uses, q_time};
      set_valid_in   = 1'b0;
      clr_valid_in   = 1'b0;
      rsp_status_in  = ST_OK;
      rsp_slot_in    = slot_ff;
      rsp_evicted_in = 1'b0;
      rsp_owner_in   = '0;
      if (cmd_ff == CMD_ACQUIRE) begin
         rsp_slot_in = '0;
         if (found_empty_ff || found_old_ff) begin
            wr_en_in       = 1'b1;
            wr_addr_in     = pick_ff;
            wr_data_in     = {owner_ff, USE_BITS'(1), TIME_BITS'(now_ff)};
            set_valid_in   = 1'b1;
            rsp_slot_in    = SLOT_BITS'(pick_ff);
            rsp_evicted_in = !found_empty_ff;
            rsp_owner_in   = found_empty_ff ? '0 : best_owner_ff;
         end else begin
            rsp_status_in = ST_FULL;
         end
      end else if (slot_bad) begin
         rsp_status_in = ST_BAD;
      end else begin
         case (cmd_ff)
            CMD_TOUCH: begin
               if (!slot_valid) begin
                  rsp_status_in = ST_BAD;
               end else begin
                  wr_en_in   = 1'b1;
                  wr_data_in = {q_owner,
                                (q_uses == {USE_BITS{1'b1}}) ? q_uses : q_uses + 1'b1,
                                TIME_BITS'(now_ff)};
               end
            end
            CMD_RELEASE: begin
               if (!slot_valid || q_uses == '0) begin
                  rsp_status_in = ST_BAD;
               end else begin
                  wr_en_in   = 1'b1;
                  wr_data_in = {q_owner, q_uses - 1'b1, q_time};
               end
            end
            CMD_DROP: begin
               if (slot_valid && q_uses != '0) begin
                  rsp_status_in = ST_IN_USE;
               end else begin
                  clr_valid_in = slot_valid;
               end
            end
            default: begin
               rsp_status_in = ST_BAD;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (ctrl_cmd.commit && set_valid_in) begin
         valid_ff[wr_addr_in] <= 1'b1;
      end else if (ctrl_cmd.commit && clr_valid_in) begin
         valid_ff[slot_idx] <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (ctrl_cmd.commit) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl_cmd.commit) begin
         rsp_status_ff  <= rsp_status_in;
         rsp_slot_ff    <= rsp_slot_in;
         rsp_evicted_ff <= rsp_evicted_in;
         rsp_owner_ff   <= rsp_owner_in;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_status        = rsp_status_ff;
   assign rsp_granted_slot  = rsp_slot_ff;
   assign rsp_evicted       = rsp_evicted_ff;
   assign rsp_evicted_owner = rsp_owner_ff;

   `PLSC_ASSERT_NEXT(a_commit_shows_result, clock, reset, ctrl_cmd.commit, rsp_valid_ff)
   `PLSC_ASSERT_NEXT(a_grant_marks_valid, clock, reset, ctrl_cmd.commit && set_valid_in, valid_ff[$past(wr_addr_in)])
   `PLSC_ASSERT_NEXT(a_empty_pick_holds, clock, reset, ctrl_cmd.scan_step && found_empty_ff, $stable(pick_ff))
   `PLSC_ASSERT_NOW(a_evict_is_ok, clock, reset, rsp_valid_ff && rsp_evicted_ff, rsp_status_ff == ST_OK)

endmodule

### hw/rtl/pinned_lru_slot_cache_unit.sv
// Top level of the pinned LRU slot cache: controller plus datapath.
//
//   Channel  Direction  Handshake            Payload
//   req      in         req_valid/req_ready  req_cmd, req_slot, req_owner_id, req_now
//   rsp      out        rsp_valid/rsp_ready  rsp_status, rsp_granted_slot, rsp_evicted,
//                                            rsp_evicted_owner
//
// An acquire request goes through the decode, scan and finish steps after acceptance until
// its result is registered; the acquire scan reads one table entry per cycle from the RAM port.
// Touch, release and drop requests do one RAM read in the decode step, then the update in the finish step.
// One request is worked on at a time; a new one is accepted while a result waits.
// Reset clears the entry valid bits at once; no clearing pass is needed.
// A stalled result holds the finished request in the last step until it is taken.
module pinned_lru_slot_cache_unit
   import plsc_pkg::*;
#(
   parameter int ENTRIES   = 16,
   parameter int USE_BITS  = 8,
   parameter int TIME_BITS = 32
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  logic [CMD_BITS-1:0]    req_cmd,
   input  logic [SLOT_BITS-1:0]   req_slot,
   input  logic [OWNER_BITS-1:0]  req_owner_id,
   input  logic [NOW_BITS-1:0]    req_now,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output logic [STATUS_BITS-1:0] rsp_status,
   output logic [SLOT_BITS-1:0]   rsp_granted_slot,
   output logic                   rsp_evicted,
   output logic [OWNER_BITS-1:0]  rsp_evicted_owner
);

   // The controller only steers; all table state lives in the datapath.
   ctrl_cmd_type  ctrl_cmd;
   dp_status_type dp_status;

   plsc_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .dp_status (dp_status),
      .ctrl_cmd  (ctrl_cmd)
   );

   plsc_datapath #(
      .ENTRIES   (ENTRIES),
      .USE_BITS  (USE_BITS),
      .TIME_BITS (TIME_BITS)
   ) u_datapath (
      .clock             (clock),
      .reset             (reset),
      .req_cmd           (req_cmd),
      .req_slot          (req_slot),
      .req_owner_id      (req_owner_id),
      .req_now           (req_now),
      .ctrl_cmd          (ctrl_cmd),
      .dp_status         (dp_status),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_status        (rsp_status),
      .rsp_granted_slot  (rsp_granted_slot),
      .rsp_evicted       (rsp_evicted),
      .rsp_evicted_owner (rsp_evicted_owner)
   );

endmodule
